[sv/tjlik_pkg.sv]
// Shared constants, widths and the CORDIC arctangent table for the leg IK pipeline.
package tjlik_pkg;

	localparam int COORD_W = 16;
	localparam int LEN_W = 15;
	localparam int HIP_W = 16;
	localparam int THIGH_W = 16;
	localparam int KNEE_W = 15;
	localparam int CFG_IDX_W = 2;

	// internal angle: signed, 1/2^20 degree
	localparam int ANG_W = 32;
	localparam int IFB = 20;
	localparam int ANGLE_FRAC_BITS = 6;
	localparam int ROUND_SHIFT = IFB - ANGLE_FRAC_BITS;

	localparam int CORDIC_STEPS = 23;
	localparam int CORDIC_W = 46;
	localparam int NORM_EXP = 40;
	localparam int NORM_STAGES = 7;
	localparam int ATAN2_LAT = 1 + NORM_STAGES + CORDIC_STEPS + 1;

	localparam logic [CFG_IDX_W-1:0] REG_COXA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEMUR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIBIA = 2'd2;

	localparam logic [LEN_W-1:0] COXA_RST = 15'd480;
	localparam logic [LEN_W-1:0] FEMUR_RST = 15'd800;
	localparam logic [LEN_W-1:0] TIBIA_RST = 15'd1280;

	localparam logic signed [ANG_W-1:0] ANG_90 = 32'sd94371840;
	localparam logic signed [ANG_W-1:0] ANG_180 = 32'sd188743680;
	localparam logic signed [ANG_W-1:0] ANG_360 = 32'sd377487360;
	localparam logic signed [ANG_W-1:0] ANG_RND = 32'sd8192;

	function automatic logic signed [ANG_W-1:0] atan_entry(input int step);
		logic signed [ANG_W-1:0] v;
		case (step)
			0: v = 32'sd47185920;
			1: v = 32'sd27855475;
			2: v = 32'sd14718068;
			3: v = 32'sd7471121;
			4: v = 32'sd3750058;
			5: v = 32'sd1876857;
			6: v = 32'sd938658;
			7: v = 32'sd469357;
			8: v = 32'sd234682;
			9: v = 32'sd117342;
			10: v = 32'sd58671;
			11: v = 32'sd29335;
			12: v = 32'sd14668;
			13: v = 32'sd7334;
			14: v = 32'sd3667;
			15: v = 32'sd1833;
			16: v = 32'sd917;
			17: v = 32'sd458;
			18: v = 32'sd229;
			19: v = 32'sd115;
			20: v = 32'sd57;
			21: v = 32'sd29;
			22: v = 32'sd14;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[sv/tjlik_delay.sv]
// Fixed-length shift register that keeps side values aligned with the pipeline.
module tjlik_delay #(
	parameter int W = 8,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_q [D];

	always_ff @(posedge clk) begin
		sr_q[0] <= d;
		for (int i = 1; i < D; i++) begin
			sr_q[i] <= sr_q[i-1];
		end
	end

	assign q = sr_q[D-1];

endmodule

[sv/tjlik_sqrt_cell.sv]
// One restoring square-root digit cell: consumes two radicand bits, makes one root bit.
module tjlik_sqrt_cell #(
	parameter int N = 16,
	parameter int W = 32
) (
	input  logic         clk,
	input  logic [W-1:0] rad_in,
	input  logic [N+1:0] rem_in,
	input  logic [N-1:0] q_in,
	output logic [W-1:0] rad_out,
	output logic [N+1:0] rem_out,
	output logic [N-1:0] q_out
);

	logic [N+3:0] rem2;
	logic [N+3:0] trial;
	logic [N+3:0] diff;
	logic         take;

	always_comb begin
		rem2 = {rem_in, rad_in[W-1 -: 2]};
		trial = {2'b00, q_in, 2'b01};
		diff = rem2 - trial;
		take = (rem2 >= trial);
	end

	always_ff @(posedge clk) begin
		rad_out <= rad_in << 2;
		if (take) begin
			rem_out <= diff[N+1:0];
			q_out <= {q_in[N-2:0], 1'b1};
		end else begin
			rem_out <= rem2[N+1:0];
			q_out <= {q_in[N-2:0], 1'b0};
		end
	end

endmodule

[sv/tjlik_sqrt.sv]
// Pipelined square root rounded to nearest: a row of digit cells and a rounding stage.
module tjlik_sqrt #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic [W-1:0]   rad,
	output logic [W/2:0]   root
);

	localparam int N = W / 2;

	logic [W-1:0] rad_c [N+1];
	logic [N+1:0] rem_c [N+1];
	logic [N-1:0] q_c   [N+1];

	assign rad_c[0] = rad;
	assign rem_c[0] = '0;
	assign q_c[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		tjlik_sqrt_cell #(.N(N), .W(W)) u_cell (
			.clk     (clk),
			.rad_in  (rad_c[i]),
			.rem_in  (rem_c[i]),
			.q_in    (q_c[i]),
			.rad_out (rad_c[i+1]),
			.rem_out (rem_c[i+1]),
			.q_out   (q_c[i+1])
		);
	end

	// remainder above the root means the true root is nearer root + 1
	always_ff @(posedge clk) begin
		root <= {1'b0, q_c[N]} + (N+1)'(rem_c[N] > {2'b00, q_c[N]});
	end

endmodule

[sv/tjlik_cordic_cell.sv]
// One vectoring CORDIC rotation step with its arctangent constant.
module tjlik_cordic_cell
	import tjlik_pkg::*;
#(
	parameter int STEP = 0
) (
	input  logic                       clk,
	input  logic signed [CORDIC_W-1:0] x_in,
	input  logic signed [CORDIC_W-1:0] y_in,
	input  logic signed [ANG_W-1:0]    z_in,
	output logic signed [CORDIC_W-1:0] x_out,
	output logic signed [CORDIC_W-1:0] y_out,
	output logic signed [ANG_W-1:0]    z_out
);

	localparam logic signed [ANG_W-1:0] ATAN_K = atan_entry(STEP);

	logic signed [CORDIC_W-1:0] xs;
	logic signed [CORDIC_W-1:0] ys;

	assign xs = x_in >>> STEP;
	assign ys = y_in >>> STEP;

	always_ff @(posedge clk) begin
		if (y_in > 0) begin
			x_out <= x_in + ys;
			y_out <= y_in - xs;
			z_out <= z_in + ATAN_K;
		end else begin
			x_out <= x_in - ys;
			y_out <= y_in + xs;
			z_out <= z_in - ATAN_K;
		end
	end

endmodule

[sv/tjlik_atan2.sv]
// Pipelined atan2: quadrant fold, staged normalization, a row of CORDIC cells, final add.
module tjlik_atan2
	import tjlik_pkg::*;
#(
	parameter int IW = 16
) (
	input  logic                    clk,
	input  logic signed [IW-1:0]    y_in,
	input  logic signed [IW-1:0]    x_in,
	output logic signed [ANG_W-1:0] angle
);

	logic signed [CORDIC_W-1:0] xe, ye, xn, yn, ay, mx;
	logic signed [ANG_W-1:0]    base;

	logic signed [CORDIC_W-1:0] x_p, y_p, m_p;
	logic signed [ANG_W-1:0]    base_p;
	logic                       zero_p;

	always_comb begin
		xe = CORDIC_W'(x_in);
		ye = CORDIC_W'(y_in);
		if (x_in[IW-1]) begin
			xn = -xe;
			yn = -ye;
			base = (yn <= 0) ? ANG_180 : -ANG_180;
		end else begin
			xn = xe;
			yn = ye;
			base = '0;
		end
		ay = yn[CORDIC_W-1] ? -yn : yn;
		mx = (xn > ay) ? xn : ay;
	end

	always_ff @(posedge clk) begin
		x_p <= xn;
		y_p <= yn;
		m_p <= mx;
		base_p <= base;
		zero_p <= (x_in == '0) && (y_in == '0);
	end

	// binary-weighted left shifts until the larger operand reaches 2^40
	logic signed [CORDIC_W-1:0] nx [NORM_STAGES+1];
	logic signed [CORDIC_W-1:0] ny [NORM_STAGES+1];
	logic signed [CORDIC_W-1:0] nm [NORM_STAGES+1];

	assign nx[0] = x_p;
	assign ny[0] = y_p;
	assign nm[0] = m_p;

	for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
		localparam int SH = (j < NORM_STAGES - 1) ? (32 >> j) : 1;
		localparam int LIM = (j < NORM_STAGES - 1) ? (NORM_EXP - SH) : NORM_EXP;
		always_ff @(posedge clk) begin
			if ((nm[j] >>> LIM) == '0) begin
				nx[j+1] <= nx[j] <<< SH;
				ny[j+1] <= ny[j] <<< SH;
				nm[j+1] <= nm[j] <<< SH;
			end else begin
				nx[j+1] <= nx[j];
				ny[j+1] <= ny[j];
				nm[j+1] <= nm[j];
			end
		end
	end

	logic signed [CORDIC_W-1:0] cx [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] cy [CORDIC_STEPS+1];
	logic signed [ANG_W-1:0]    cz [CORDIC_STEPS+1];

	assign cx[0] = nx[NORM_STAGES];
	assign cy[0] = ny[NORM_STAGES];
	assign cz[0] = '0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		tjlik_cordic_cell #(.STEP(i)) u_cell (
			.clk   (clk),
			.x_in  (cx[i]),
			.y_in  (cy[i]),
			.z_in  (cz[i]),
			.x_out (cx[i+1]),
			.y_out (cy[i+1]),
			.z_out (cz[i+1])
		);
	end

	logic [ANG_W:0] side_d;

	tjlik_delay #(.W(ANG_W + 1), .D(NORM_STAGES + CORDIC_STEPS)) u_side (
		.clk (clk),
		.d   ({zero_p, base_p}),
		.q   (side_d)
	);

	always_ff @(posedge clk) begin
		if (side_d[ANG_W]) begin
			angle <= '0;
		end else begin
			angle <= $signed(side_d[ANG_W-1:0]) + cz[CORDIC_STEPS];
		end
	end

endmodule

[sv/three_joint_leg_inverse_kinematics_top.sv]
// Top level of the three-joint leg inverse kinematics pipeline.
// Fully pipelined: a foot target may be started in every clock cycle and busy never rises.
// Each target gives one result, marked by done for one cycle; the receiver cannot
// stall, so results must be taken as they appear. The latency is set by the dependent
// chain reach root, distance root, the law-of-cosines root (32 digit cells) and its
// CORDIC atan2 (32 stages). Segment lengths are written through the cfg port, always
// ready, and may only change while no result is pending.
module three_joint_leg_inverse_kinematics_top
	import tjlik_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [COORD_W-1:0]   target_x,
	input  logic signed [COORD_W-1:0]   target_y,
	input  logic signed [COORD_W-1:0]   target_z,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [LEN_W-1:0]            cfg_data,
	output logic                        done,
	output logic signed [HIP_W-1:0]     hip_angle,
	output logic signed [THIGH_W-1:0]   thigh_angle,
	output logic signed [KNEE_W-1:0]    knee_angle,
	output logic                        degenerate
);

	localparam int LAT = 112;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration
	logic [LEN_W-1:0] coxa_q, femur_q, tibia_q;
	logic [29:0]      ff_q, tt_q;
	logic [31:0]      ft2_q, ftsq_q;
	logic [15:0]      ftsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coxa_q <= COXA_RST;
			femur_q <= FEMUR_RST;
			tibia_q <= TIBIA_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COXA:  coxa_q <= cfg_data;
				REG_FEMUR: femur_q <= cfg_data;
				REG_TIBIA: tibia_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ftsum = {1'b0, femur_q} + {1'b0, tibia_q};

	always_ff @(posedge clk) begin
		ff_q <= 30'(femur_q) * 30'(femur_q);
		tt_q <= 30'(tibia_q) * 30'(tibia_q);
		ft2_q <= {31'(femur_q) * 31'(tibia_q), 1'b0};
		ftsq_q <= 32'(ftsum) * 32'(ftsum);
	end

	// valid chain
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	assign done = vld_q[LAT-1];

	// front end: squares and horizontal reach
	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1;
	logic [31:0]               xx_s2, yy_s2, zz_s2;
	logic [31:0]               r2_s3;
	logic [16:0]               reach_s20;

	always_ff @(posedge clk) begin
		x_s1 <= target_x;
		y_s1 <= target_y;
		z_s1 <= target_z;
		xx_s2 <= 32'(x_s1 * x_s1);
		yy_s2 <= 32'(y_s1 * y_s1);
		zz_s2 <= 32'(z_s1 * z_s1);
		r2_s3 <= xx_s2 + yy_s2;
	end

	tjlik_sqrt #(.W(32)) u_reach (
		.clk  (clk),
		.rad  (r2_s3),
		.root (reach_s20)
	);

	// leg plane: c = reach - coxa, L^2 = z^2 + c^2
	logic signed [17:0]        c_s21;
	logic [COORD_W-1:0]        z_s21;
	logic [31:0]               zz_s22;
	logic [31:0]               cc_s22;
	logic [32:0]               lsq_s23;
	logic [32:0]               lsq_s41;
	logic [17:0]               l_s41;

	tjlik_delay #(.W(COORD_W), .D(20)) u_z_dly (
		.clk (clk),
		.d   (z_s1),
		.q   (z_s21)
	);

	tjlik_delay #(.W(32), .D(20)) u_zz_dly (
		.clk (clk),
		.d   (zz_s2),
		.q   (zz_s22)
	);

	always_ff @(posedge clk) begin
		c_s21 <= $signed({1'b0, reach_s20}) - $signed({3'b000, coxa_q});
		cc_s22 <= 32'(c_s21 * c_s21);
		lsq_s23 <= {1'b0, zz_s22} + {1'b0, cc_s22};
	end

	tjlik_sqrt #(.W(34)) u_dist (
		.clk  (clk),
		.rad  ({1'b0, lsq_s23}),
		.root (l_s41)
	);

	tjlik_delay #(.W(33), .D(18)) u_lsq_dly (
		.clk (clk),
		.d   (lsq_s23),
		.q   (lsq_s41)
	);

	// cosine numerators and denominators; lane 0 is the thigh, lane 1 the knee
	logic [32:0]        fl_l;
	logic signed [34:0] n_s42 [2];
	logic [31:0]        d_s42 [2];
	logic               dg2_s42, dg3_s42, le_s42;

	assign fl_l = 33'(femur_q) * 33'(l_s41);

	always_ff @(posedge clk) begin
		d_s42[0] <= {fl_l[30:0], 1'b0};
		d_s42[1] <= ft2_q;
		n_s42[0] <= $signed({2'b00, lsq_s41}) + $signed({5'b0, ff_q}) - $signed({5'b0, tt_q});
		n_s42[1] <= $signed({5'b0, ff_q}) + $signed({5'b0, tt_q}) - $signed({2'b00, lsq_s41});
		dg2_s42 <= (fl_l == '0);
		dg3_s42 <= (ft2_q == '0);
		le_s42 <= ({1'b0, ftsq_q} >= lsq_s41);
	end

	// acos(n/d) = atan2(sqrt(d^2 - n^2), n) with n clamped to [-d, d]
	logic signed [34:0]      dsx [2];
	logic signed [34:0]      ncl [2];
	logic signed [32:0]      nc_s43 [2];
	logic [31:0]             mag_s43 [2];
	logic [31:0]             d_s43 [2];
	logic [63:0]             dd_s44 [2];
	logic [63:0]             nn_s44 [2];
	logic [63:0]             diff_s45 [2];
	logic [32:0]             s_s78 [2];
	logic [32:0]             nc_s78 [2];
	logic signed [ANG_W-1:0] ac_s110 [2];

	for (genvar g = 0; g < 2; g++) begin : g_lane
		always_comb begin
			dsx[g] = $signed({3'b000, d_s42[g]});
			if (n_s42[g] > dsx[g]) begin
				ncl[g] = dsx[g];
			end else if (n_s42[g] < -dsx[g]) begin
				ncl[g] = -dsx[g];
			end else begin
				ncl[g] = n_s42[g];
			end
		end

		always_ff @(posedge clk) begin
			nc_s43[g] <= ncl[g][32:0];
			mag_s43[g] <= ncl[g][34] ? 32'(-ncl[g]) : 32'(ncl[g]);
			d_s43[g] <= d_s42[g];
			dd_s44[g] <= 64'(d_s43[g]) * 64'(d_s43[g]);
			nn_s44[g] <= 64'(mag_s43[g]) * 64'(mag_s43[g]);
			diff_s45[g] <= dd_s44[g] - nn_s44[g];
		end

		tjlik_delay #(.W(33), .D(35)) u_nc_dly (
			.clk (clk),
			.d   (nc_s43[g]),
			.q   (nc_s78[g])
		);

		tjlik_sqrt #(.W(64)) u_sin (
			.clk  (clk),
			.rad  (diff_s45[g]),
			.root (s_s78[g])
		);

		tjlik_atan2 #(.IW(34)) u_acos (
			.clk   (clk),
			.y_in  ($signed({1'b0, s_s78[g]})),
			.x_in  ($signed({nc_s78[g][32], nc_s78[g]})),
			.angle (ac_s110[g])
		);
	end

	// hip and thigh base angles
	logic signed [ANG_W-1:0] hip_s33, hip_s110;
	logic signed [ANG_W-1:0] tz_s53, tz_s110;
	logic                    qneg_s110;
	logic [2:0]              flg_s110;

	tjlik_atan2 #(.IW(COORD_W)) u_hip (
		.clk   (clk),
		.y_in  (y_s1),
		.x_in  (x_s1),
		.angle (hip_s33)
	);

	tjlik_atan2 #(.IW(18)) u_thigh (
		.clk   (clk),
		.y_in  ($signed({{2{z_s21[COORD_W-1]}}, z_s21})),
		.x_in  (c_s21),
		.angle (tz_s53)
	);

	tjlik_delay #(.W(ANG_W), .D(77)) u_hip_dly (
		.clk (clk),
		.d   (hip_s33),
		.q   (hip_s110)
	);

	tjlik_delay #(.W(ANG_W), .D(57)) u_tz_dly (
		.clk (clk),
		.d   (tz_s53),
		.q   (tz_s110)
	);

	tjlik_delay #(.W(1), .D(109)) u_qneg_dly (
		.clk (clk),
		.d   (x_s1[COORD_W-1] & y_s1[COORD_W-1]),
		.q   (qneg_s110)
	);

	tjlik_delay #(.W(3), .D(68)) u_flg_dly (
		.clk (clk),
		.d   ({le_s42, dg3_s42, dg2_s42}),
		.q   (flg_s110)
	);

	// final sums, then round to 1/64 degree
	logic signed [ANG_W-1:0] hip_s111, thigh_s111, knee_s111;
	logic                    degen_s111;
	logic signed [ANG_W-1:0] hip_r, thigh_r, knee_r;

	always_ff @(posedge clk) begin
		hip_s111 <= hip_s110 + (qneg_s110 ? ANG_360 : '0);
		thigh_s111 <= tz_s110 + (flg_s110[0] ? '0 : ac_s110[0]);
		knee_s111 <= (flg_s110[1] ? '0 : ac_s110[1]) - (flg_s110[2] ? ANG_90 : '0);
		degen_s111 <= flg_s110[0] | flg_s110[1];
	end

	assign hip_r = (hip_s111 + ANG_RND) >>> ROUND_SHIFT;
	assign thigh_r = (thigh_s111 + ANG_RND) >>> ROUND_SHIFT;
	assign knee_r = (knee_s111 + ANG_RND) >>> ROUND_SHIFT;

	always_ff @(posedge clk) begin
		hip_angle <= hip_r[HIP_W-1:0];
		thigh_angle <= thigh_r[THIGH_W-1:0];
		knee_angle <= knee_r[KNEE_W-1:0];
		degenerate <= degen_s111;
	end

	// every started target comes out as a done pulse, and no done comes without a start
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("started target produced no result");

	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching start");

endmodule

[bench/three_joint_leg_inverse_kinematics_top_tb.sv]
// Self-checking bench for the leg IK pipeline: directed and random foot targets over several leg geometries.
module three_joint_leg_inverse_kinematics_top_tb;
	import tjlik_pkg::*;

	typedef struct {
		logic signed [HIP_W-1:0]   hip;
		logic signed [THIGH_W-1:0] thigh;
		logic signed [KNEE_W-1:0]  knee;
		logic                      degen;
	} joint_angles_t;

	class angle_scoreboard;
		longint coxa_len, femur_len, tibia_len;
		joint_angles_t pending[$];
		int errors;

		function new();
			coxa_len = COXA_RST;
			femur_len = FEMUR_RST;
			tibia_len = TIBIA_RST;
			errors = 0;
		endfunction

		function longint unsigned root_nearest(longint unsigned v);
			longint unsigned r, b, t;
			r = 0;
			b = 64'd1 << 62;
			t = v;
			while (b > t)
				b >>= 2;
			while (b != 0) begin
				if (t >= r + b) begin
					t -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			if (v - r * r > r)
				r++;
			return r;
		endfunction

		function longint atan_step(int i);
			longint tab[CORDIC_STEPS] = '{47185920, 27855475, 14718068, 7471121, 3750058,
				1876857, 938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667,
				1833, 917, 458, 229, 115, 57, 29, 14};
			return tab[i];
		endfunction

		// vectoring CORDIC, result in 1/2^20 degree
		function longint arctan2(longint y, longint x);
			longint base, acc, m, ay, nx, ny;
			base = 0;
			acc = 0;
			if (x == 0 && y == 0)
				return 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				base = (y <= 0) ? (longint'(180) << IFB) : -(longint'(180) << IFB);
			end
			ay = (y < 0) ? -y : y;
			m = (x > ay) ? x : ay;
			while (m < (longint'(1) << NORM_EXP)) begin
				m *= 2;
				x *= 2;
				y *= 2;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (y > 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					acc += atan_step(i);
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					acc -= atan_step(i);
				end
				x = nx;
				y = ny;
			end
			return base + acc;
		endfunction

		// acos(n/d), quotient clamped to [-1, 1]
		function longint arccos_ratio(longint n, longint d);
			longint unsigned dd, nn;
			if (n > d)
				n = d;
			if (n < -d)
				n = -d;
			dd = longint'(d) * longint'(d);
			nn = (n < 0) ? -n : n;
			nn = nn * nn;
			return arctan2(longint'(root_nearest(dd - nn)), n);
		endfunction

		function longint to_field(longint a);
			return (a + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
		endfunction

		function void note_target(logic signed [COORD_W-1:0] tx, logic signed [COORD_W-1:0] ty,
				logic signed [COORD_W-1:0] tz);
			longint x, y, z, reach, c, lsq, l, hip, thigh, knee, d2, d3, ft;
			joint_angles_t e;
			x = tx;
			y = ty;
			z = tz;
			e.degen = 1'b0;
			reach = longint'(root_nearest(x * x + y * y));
			c = reach - coxa_len;
			lsq = z * z + c * c;
			l = longint'(root_nearest(lsq));
			hip = arctan2(y, x);
			if (x < 0 && y < 0)
				hip += longint'(360) << IFB;
			thigh = arctan2(z, c);
			d2 = 2 * femur_len * l;
			if (d2 == 0)
				e.degen = 1'b1;
			else
				thigh += arccos_ratio(lsq + femur_len * femur_len - tibia_len * tibia_len, d2);
			d3 = 2 * femur_len * tibia_len;
			if (d3 == 0) begin
				e.degen = 1'b1;
				knee = 0;
			end else begin
				knee = arccos_ratio(femur_len * femur_len + tibia_len * tibia_len - lsq, d3);
			end
			ft = femur_len + tibia_len;
			if (lsq <= ft * ft)
				knee -= longint'(90) << IFB;
			e.hip = HIP_W'(to_field(hip));
			e.thigh = THIGH_W'(to_field(thigh));
			e.knee = KNEE_W'(to_field(knee));
			pending.push_back(e);
		endfunction

		function void check_result(joint_angles_t got);
			joint_angles_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result hip=%0d thigh=%0d knee=%0d degen=%0b", $time,
					got.hip, got.thigh, got.knee, got.degen);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.hip !== e.hip) begin
				$display("%0t: hip_angle expected %0d actual %0d", $time, e.hip, got.hip);
				errors++;
			end
			if (got.thigh !== e.thigh) begin
				$display("%0t: thigh_angle expected %0d actual %0d", $time, e.thigh, got.thigh);
				errors++;
			end
			if (got.knee !== e.knee) begin
				$display("%0t: knee_angle expected %0d actual %0d", $time, e.knee, got.knee);
				errors++;
			end
			if (got.degen !== e.degen) begin
				$display("%0t: degenerate expected %0b actual %0b", $time, e.degen, got.degen);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, done, degenerate;
	logic signed [COORD_W-1:0] target_x, target_y, target_z;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0] cfg_data;
	logic signed [HIP_W-1:0] hip_angle;
	logic signed [THIGH_W-1:0] thigh_angle;
	logic signed [KNEE_W-1:0] knee_angle;

	angle_scoreboard sb = new();
	int idle_pct;
	int quiet_cycles;
	joint_angles_t seen;

	localparam int PIPE_DRAIN = 150;
	localparam int WATCHDOG_LIMIT = 3000;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	three_joint_leg_inverse_kinematics_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .hip_angle(hip_angle),
		.thigh_angle(thigh_angle), .knee_angle(knee_angle), .degenerate(degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_target(target_x, target_y, target_z);
			if (done) begin
				seen.hip = hip_angle;
				seen.thigh = thigh_angle;
				seen.knee = knee_angle;
				seen.degen = degenerate;
				sb.check_result(seen);
			end
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	task automatic send_target(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
			logic signed [COORD_W-1:0] z);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		target_x <= x;
		target_y <= y;
		target_z <= z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_COXA: sb.coxa_len = val;
			REG_FEMUR: sb.femur_len = val;
			REG_TIBIA: sb.tibia_len = val;
			default: ;
		endcase
	endtask

	task automatic set_leg(logic [LEN_W-1:0] cx, logic [LEN_W-1:0] fm, logic [LEN_W-1:0] tb);
		write_reg(REG_COXA, cx);
		write_reg(REG_FEMUR, fm);
		write_reg(REG_TIBIA, tb);
	endtask

	// mostly points near the workspace, some full-range noise, some small points close to the axes
	task automatic random_target();
		int sel;
		logic signed [COORD_W-1:0] x, y, z;
		sel = $urandom_range(99);
		if (sel < 30) begin
			x = COORD_W'($urandom);
			y = COORD_W'($urandom);
			z = COORD_W'($urandom);
		end else if (sel < 85) begin
			x = COORD_W'($signed($urandom_range(6000)) - 3000);
			y = COORD_W'($signed($urandom_range(6000)) - 3000);
			z = COORD_W'($signed($urandom_range(4000)) - 2000);
		end else begin
			x = ($urandom_range(2) == 0) ? 16'sd0 :
				COORD_W'($signed($urandom_range(200)) - 100);
			y = ($urandom_range(2) == 0) ? 16'sd0 :
				COORD_W'($signed($urandom_range(200)) - 100);
			z = ($urandom_range(1) == 0) ? 16'sd0 : COORD_W'($urandom);
		end
		send_target(x, y, z);
	endtask

	initial begin
		logic [LEN_W-1:0] legs[7][3];
		legs = '{'{COXA_RST, FEMUR_RST, TIBIA_RST}, '{15'd0, 15'd0, 15'd0},
			'{15'd32767, 15'd32767, 15'd32767}, '{15'd480, 15'd0, 15'd1280},
			'{15'd480, 15'd800, 15'd0}, '{15'd0, 15'd1000, 15'd1000},
			'{15'd200, 15'd700, 15'd1500}};
		arst_n = 1'b0;
		start = 1'b0;
		target_x = '0;
		target_y = '0;
		target_z = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet_cycles = 0;
		idle_pct = 13;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: origin, axes, extremes, reach exactly the coxa, both-negative quadrant
		send_target(0, 0, 0);
		send_target(-100, 0, 0);
		send_target(0, -100, 50);
		send_target(0, 100, -50);
		send_target(-5, -5, 0);
		send_target(480, 0, 0);
		send_target(480, 0, 300);
		send_target(1280, 0, -800);
		send_target(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_target(-16'sh8000, -16'sh8000, -16'sh8000);
		send_target(16'sh7FFF, -16'sh8000, 0);
		send_target(-16'sh8000, 16'sh7FFF, 16'sh7FFF);
		send_target(1000, 1000, -500);
		send_target(-1000, 1000, 500);
		send_target(2560, 0, 0);
		send_target(0, 0, 16'sh7FFF);
		drain();
		write_reg(REG_NONE, 15'h7FFF);

		for (int p = 0; p < 14; p++) begin
			if (p < 7)
				set_leg(legs[p][0], legs[p][1], legs[p][2]);
			else
				set_leg(LEN_W'($urandom_range(32767) >> $urandom_range(14)),
					LEN_W'($urandom_range(32767) >> $urandom_range(14)),
					LEN_W'($urandom_range(32767) >> $urandom_range(14)));
			idle_pct = (p < 5) ? 13 : (p < 10) ? 49 : 0;
			repeat (107) random_target();
			drain();
		end

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[three_joint_leg_inverse_kinematics_top.f]
sv/tjlik_pkg.sv
sv/tjlik_delay.sv
sv/tjlik_sqrt_cell.sv
sv/tjlik_sqrt.sv
sv/tjlik_cordic_cell.sv
sv/tjlik_atan2.sv
sv/three_joint_leg_inverse_kinematics_top.sv
bench/three_joint_leg_inverse_kinematics_top_tb.sv
